@@ hdl/spkt_pkg.sv @@
// spkt_pkg: shared types and codes of the sorted prefix key table
// used by spkt_ctrl, spkt_dpath and sorted_prefix_key_table; no dependencies
`default_nettype none
package spkt_pkg;

  localparam int KEY_LEN_W = 3;   // width of the key_length field
  localparam int LEN_W     = 4;   // internal byte-count width, holds 0..8

  localparam logic [1:0] F_LOOKUP = 2'd0;
  localparam logic [1:0] F_INSERT = 2'd1;
  localparam logic [1:0] F_REMOVE = 2'd2;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_EXACT  = 2'd1;
  localparam logic [1:0] ST_EXT    = 2'd2;
  localparam logic [1:0] ST_ABBREV = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_CMP, S_CHK_LO, S_CHK_PV, S_CNT0, S_CNT,
    S_PLAN, S_RM, S_RM_FIN, S_INS0, S_INS, S_INS_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_upd;
    logic chk_lo_rd;
    logic chk_lo;
    logic chk_pv_rd;
    logic chk_pv;
    logic cnt_start;
    logic cnt_step;
    logic plan;
    logic rm_start;
    logic rm_step;
    logic rm_fin;
    logic ins_start;
    logic ins_step;
    logic ins_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic need_prev;
    logic cnt_go;
    logic cnt_cont;
    logic is_mod;
    logic is_ins;
    logic full;
    logic rm_go;
    logic rm_cont;
    logic ins_go;
    logic ins_cont;
  } sts_t;

endpackage
`default_nettype wire

@@ hdl/spkt_ram.sv @@
// spkt_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module spkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/spkt_ctrl.sv @@
// spkt_ctrl: sequencer of search, count, shift and result hand-off
// depends on spkt_pkg
`default_nettype none
module spkt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire spkt_pkg::sts_t sts,
  output spkt_pkg::cmd_t      cmd
);

  spkt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == spkt_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spkt_pkg::S_IDLE:     if (in_valid) state_nxt = spkt_pkg::S_SRCH;
      spkt_pkg::S_SRCH:     state_nxt = sts.lo_lt_hi ? spkt_pkg::S_SRCH_CMP : spkt_pkg::S_CHK_LO;
      spkt_pkg::S_SRCH_CMP: state_nxt = spkt_pkg::S_SRCH;
      spkt_pkg::S_CHK_LO:   state_nxt = sts.need_prev ? spkt_pkg::S_CHK_PV : spkt_pkg::S_CNT0;
      spkt_pkg::S_CHK_PV:   state_nxt = spkt_pkg::S_CNT0;
      spkt_pkg::S_CNT0:     state_nxt = sts.cnt_go ? spkt_pkg::S_CNT : spkt_pkg::S_PLAN;
      spkt_pkg::S_CNT:      if (!sts.cnt_cont) state_nxt = spkt_pkg::S_PLAN;
      spkt_pkg::S_PLAN: begin
        if (!sts.is_mod || sts.full) state_nxt = spkt_pkg::S_DONE;
        else if (sts.rm_go)          state_nxt = spkt_pkg::S_RM;
        else                         state_nxt = spkt_pkg::S_RM_FIN;
      end
      spkt_pkg::S_RM:       if (!sts.rm_cont) state_nxt = spkt_pkg::S_RM_FIN;
      spkt_pkg::S_RM_FIN:   state_nxt = sts.is_ins ? spkt_pkg::S_INS0 : spkt_pkg::S_DONE;
      spkt_pkg::S_INS0:     state_nxt = sts.ins_go ? spkt_pkg::S_INS : spkt_pkg::S_INS_WR;
      spkt_pkg::S_INS:      if (!sts.ins_cont) state_nxt = spkt_pkg::S_INS_WR;
      spkt_pkg::S_INS_WR:   state_nxt = spkt_pkg::S_DONE;
      spkt_pkg::S_DONE:     if (!out_valid_r || out_ready) state_nxt = spkt_pkg::S_IDLE;
      default:              state_nxt = spkt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      spkt_pkg::S_IDLE:     cmd.load = in_valid;
      spkt_pkg::S_SRCH: begin
        cmd.srch_rd   = sts.lo_lt_hi;
        cmd.chk_lo_rd = !sts.lo_lt_hi;
      end
      spkt_pkg::S_SRCH_CMP: cmd.srch_upd = 1'b1;
      spkt_pkg::S_CHK_LO: begin
        cmd.chk_lo    = 1'b1;
        cmd.chk_pv_rd = sts.need_prev;
      end
      spkt_pkg::S_CHK_PV:   cmd.chk_pv = 1'b1;
      spkt_pkg::S_CNT0:     cmd.cnt_start = 1'b1;
      spkt_pkg::S_CNT:      cmd.cnt_step = 1'b1;
      spkt_pkg::S_PLAN: begin
        cmd.plan     = 1'b1;
        cmd.rm_start = sts.is_mod && !sts.full;
      end
      spkt_pkg::S_RM:       cmd.rm_step = 1'b1;
      spkt_pkg::S_RM_FIN:   cmd.rm_fin = 1'b1;
      spkt_pkg::S_INS0:     cmd.ins_start = 1'b1;
      spkt_pkg::S_INS:      cmd.ins_step = 1'b1;
      spkt_pkg::S_INS_WR:   cmd.ins_wr = 1'b1;
      spkt_pkg::S_DONE:     cmd.out_load = !out_valid_r || out_ready;
      default:              cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spkt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/spkt_dpath.sv @@
// spkt_dpath: key compare, search bounds, counters, shift pointers and result registers
// depends on spkt_pkg and spkt_ram
`default_nettype none
module spkt_dpath #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 6,
  parameter int HANDLE_BITS = 16,
  localparam int KW    = 8 * KEY_BYTES,
  localparam int IDX_W = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire spkt_pkg::cmd_t                cmd,
  output spkt_pkg::sts_t                     sts,
  input  wire logic [1:0]                    in_func,
  input  wire logic [KW-1:0]                 in_key_value,
  input  wire logic [spkt_pkg::KEY_LEN_W-1:0] in_key_length,
  input  wire logic [HANDLE_BITS-1:0]        in_title_handle,
  output logic      [1:0]                    out_match_status,
  output logic      [IDX_W-1:0]              out_entry_index,
  output logic      [IDX_W-1:0]              out_match_count,
  output logic      [HANDLE_BITS-1:0]        out_found_handle,
  output logic                               out_table_full
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = KW + HANDLE_BITS;
  localparam int LW = spkt_pkg::LEN_W;

  function automatic logic [KW-1:0] len_mask(input logic [LW-1:0] n);
    logic [KW-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (LW'(b) < n) m[KW-8-8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [LW-1:0] key_len(input logic [KW-1:0] k);
    logic [LW-1:0] n;
    logic          stop;
    n    = '0;
    stop = 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (!stop && k[KW-8-8*b +: 8] != 8'h00) n = n + 1'b1;
      else stop = 1'b1;
    end
    return n;
  endfunction

  logic [1:0]             func_r;
  logic [KW-1:0]          qkey_r;
  logic [LW-1:0]          qlen_r;
  logic [HANDLE_BITS-1:0] hdl_r, fhdl_r;
  logic [IDX_W-1:0]       cnt_r, lo_r, hi_r, idx_r, mc_r, ptr_r, dst_r;
  logic [1:0]             stat_r;
  logic                   full_r;

  // ram ports
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [EW-1:0]    wdata, rdata;

  spkt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr[AW-1:0]),
    .rdata (rdata)
  );

  logic [KW-1:0]          rkey, qm, rmask, in_mask;
  logic [HANDLE_BITS-1:0] rhdl;
  logic [LW-1:0]          rn, in_len, in_ql;
  logic                   r_eq, r_lt, r_ab, r_ext, lo_lt_cnt, hit_lo, is_mod, is_ins;
  logic [IDX_W:0]         sum_lh;
  logic [IDX_W-1:0]       mid, pos_w, rem_w, left_w, ptr_inc;

  assign rkey  = rdata[EW-1:HANDLE_BITS];
  assign rhdl  = rdata[HANDLE_BITS-1:0];
  assign qm    = len_mask(qlen_r);
  assign r_eq  = (rkey & qm) == qkey_r;
  assign r_lt  = (rkey & qm) < qkey_r;
  assign rn    = key_len(rkey);
  assign rmask = len_mask(rn);
  assign r_ab  = (qkey_r & rmask) == (rkey & rmask);
  assign r_ext = rn > qlen_r;

  // effective query length: clipped to key size and to the first zero byte
  always_comb begin
    in_ql  = (LW'(in_key_length) > LW'(KEY_BYTES)) ? LW'(KEY_BYTES) : LW'(in_key_length);
    in_len = key_len(in_key_value);
    if (in_len < in_ql) in_ql = in_len;
    in_mask = len_mask(in_ql);
  end

  assign lo_lt_cnt = lo_r < cnt_r;
  assign hit_lo    = lo_lt_cnt && (r_eq || r_ab);
  assign sum_lh    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = sum_lh[IDX_W:1];
  assign is_ins    = func_r == spkt_pkg::F_INSERT;
  assign is_mod    = is_ins || (func_r == spkt_pkg::F_REMOVE);
  assign pos_w     = (stat_r == spkt_pkg::ST_ABBREV) ? idx_r + 1'b1 : idx_r;
  assign rem_w     = (stat_r != spkt_pkg::ST_NONE && stat_r != spkt_pkg::ST_ABBREV)
                     ? mc_r : '0;
  assign left_w    = cnt_r - rem_w;
  assign ptr_inc   = ptr_r + 1'b1;

  always_comb begin
    sts.lo_lt_hi  = lo_r < hi_r;
    sts.need_prev = !hit_lo && (lo_r != '0);
    sts.cnt_go    = idx_r < cnt_r;
    sts.cnt_cont  = r_eq && (ptr_inc < cnt_r);
    sts.is_mod    = is_mod;
    sts.is_ins    = is_ins;
    sts.full      = is_ins && (left_w >= IDX_W'(TABLE_DEPTH));
    sts.rm_go     = (rem_w != '0) && ((pos_w + rem_w) < cnt_r);
    sts.rm_cont   = ptr_inc < cnt_r;
    sts.ins_go    = cnt_r > pos_w;
    sts.ins_cont  = ptr_r > pos_w;
  end

  always_comb begin
    raddr = ptr_inc;
    if (cmd.srch_rd)   raddr = mid;
    if (cmd.chk_lo_rd) raddr = lo_r;
    if (cmd.chk_pv_rd) raddr = lo_r - 1'b1;
    if (cmd.cnt_start) raddr = idx_r;
    if (cmd.rm_start)  raddr = pos_w + rem_w;
    if (cmd.ins_start) raddr = cnt_r - 1'b1;
    if (cmd.ins_step)  raddr = ptr_r - 1'b1;
  end

  always_comb begin
    we    = cmd.rm_step || cmd.ins_step || cmd.ins_wr;
    waddr = cmd.ins_wr ? pos_w : dst_r;
    wdata = cmd.ins_wr ? {qkey_r, hdl_r} : rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      if (cmd.rm_fin) cnt_r <= left_w;
      if (cmd.ins_wr) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      qkey_r <= in_key_value & in_mask;
      qlen_r <= in_ql;
      hdl_r  <= in_title_handle;
      lo_r   <= '0;
      hi_r   <= cnt_r;
      full_r <= 1'b0;
    end
    if (cmd.srch_upd) begin
      if (r_lt) lo_r <= mid + 1'b1;
      else      hi_r <= mid;
    end
    if (cmd.chk_lo) begin
      idx_r <= lo_r;
      if (lo_lt_cnt && r_eq) begin
        stat_r <= r_ext ? spkt_pkg::ST_EXT : spkt_pkg::ST_EXACT;
        fhdl_r <= rhdl;
      end else if (lo_lt_cnt && r_ab) begin
        stat_r <= spkt_pkg::ST_ABBREV;
        fhdl_r <= rhdl;
      end else begin
        stat_r <= spkt_pkg::ST_NONE;
        fhdl_r <= '0;
      end
    end
    if (cmd.chk_pv && r_ab) begin
      stat_r <= spkt_pkg::ST_ABBREV;
      idx_r  <= lo_r - 1'b1;
      fhdl_r <= rhdl;
    end
    if (cmd.cnt_start) begin
      ptr_r <= idx_r;
      mc_r  <= '0;
    end
    if (cmd.cnt_step && r_eq) begin
      ptr_r <= ptr_inc;
      mc_r  <= mc_r + 1'b1;
    end
    if (cmd.plan) full_r <= sts.full;
    if (cmd.rm_start) begin
      ptr_r <= pos_w + rem_w;
      dst_r <= pos_w;
    end
    if (cmd.rm_step) begin
      ptr_r <= ptr_inc;
      dst_r <= dst_r + 1'b1;
    end
    if (cmd.ins_start) begin
      ptr_r <= cnt_r - 1'b1;
      dst_r <= cnt_r;
    end
    if (cmd.ins_step) begin
      ptr_r <= ptr_r - 1'b1;
      dst_r <= dst_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_match_status <= stat_r;
      out_entry_index  <= is_mod ? pos_w : idx_r;
      out_match_count  <= (is_mod && !full_r) ? rem_w : mc_r;
      out_found_handle <= fhdl_r;
      out_table_full   <= full_r;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sorted_prefix_key_table.sv @@
// sorted_prefix_key_table: top level, joins controller, datapath and table ram
// depends on spkt_pkg, spkt_ctrl, spkt_dpath (and through it spkt_ram)
`default_nettype none
// one item is in work at a time; in_ready is high only while the sequencer idles.
// timing is set by the table ram, which has one write and one read port and a
// registered read: each halving of the binary search takes a read state and a
// compare state, the landing check reads the low bound and, if needed, the entry
// before it, then the matching entries are counted one after another; a remove or
// insert then moves the entries down or up one at a time between setup states.
// the result sits in an output register, so a beat waiting on out_ready stalls
// only the hand-off of the next result.
// no clearing pass after reset: only entries below the fill count are ever used
module sorted_prefix_key_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 6,
  parameter int HANDLE_BITS = 16,
  localparam int IDX_W = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input beat
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_func,
  input  wire logic [8*KEY_BYTES-1:0]         in_key_value,
  input  wire logic [spkt_pkg::KEY_LEN_W-1:0] in_key_length,
  input  wire logic [HANDLE_BITS-1:0]         in_title_handle,
  // result beat
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [1:0]                     out_match_status,
  output logic      [IDX_W-1:0]               out_entry_index,
  output logic      [IDX_W-1:0]               out_match_count,
  output logic      [HANDLE_BITS-1:0]         out_found_handle,
  output logic                                out_table_full
);

  spkt_pkg::cmd_t cmd;   // sequencer commands to the datapath
  spkt_pkg::sts_t sts;   // compare and bound flags back to the sequencer

  spkt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spkt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_key_value     (in_key_value),
    .in_key_length    (in_key_length),
    .in_title_handle  (in_title_handle),
    .out_match_status (out_match_status),
    .out_entry_index  (out_entry_index),
    .out_match_count  (out_match_count),
    .out_found_handle (out_found_handle),
    .out_table_full   (out_table_full)
  );

endmodule
`default_nettype wire
